FILE: rtl/sorted_timer_queue_top_macros.svh
// Assertion macros used by the timer queue checker.
`ifndef SORTED_TIMER_QUEUE_TOP_MACROS_SVH
`define SORTED_TIMER_QUEUE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define STQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define STQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/stq_pkg.sv
// Shared types and constants of the sorted timer queue.
package stq_pkg;

  localparam int NUM_TIMERS_DEF = 32;
  localparam int MAX_OUT        = 32;
  localparam int OUT_CNT_W      = 6;

  localparam int FUNC_W  = 3;
  localparam int SLOT_W  = 5;
  localparam int OWNER_W = 8;
  localparam int DATA_W  = 32;
  localparam int KIND_W  = 2;
  localparam int IN_W    = 80;
  localparam int OUT_W   = 48;

  localparam logic [FUNC_W-1:0] FUNC_TICK       = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_ALLOC      = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_SETUP      = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_ARM        = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CANCEL     = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_FREE       = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_CANCEL_ALL = 3'd6;

  localparam logic [KIND_W-1:0] KIND_STATUS  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELIVER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TASK    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_BAD     = 2'd3;

  localparam logic [1:0] ST_FREE  = 2'd0;
  localparam logic [1:0] ST_ALLOC = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_ARM_INS,
    S_ALLOC,
    S_CANCEL_ALL,
    S_POP,
    S_TS,
    S_FIN,
    S_STATUS
  } stq_state_t;

  // Chain operation broadcast to every cell; at most one bit set.
  typedef struct packed {
    logic ins;
    logic rem;
  } stq_chain_ctrl_t;

endpackage

FILE: rtl/stq_cell.sv
// One position of the sorted expiry list.
module stq_cell #(
  parameter int SW = 5
) (
  input  logic                   clk,
  input  logic                   rst,
  input  stq_pkg::stq_chain_ctrl_t ctrl,
  input  logic [SW-1:0]          new_id,
  input  logic [31:0]            new_exp,
  input  logic [SW-1:0]          rem_id,
  input  logic                   left_valid,
  input  logic [SW-1:0]          left_id,
  input  logic [31:0]            left_exp,
  input  logic                   right_valid,
  input  logic [SW-1:0]          right_id,
  input  logic [31:0]            right_exp,
  input  logic                   ins_in,
  input  logic                   rem_in,
  output logic                   valid,
  output logic [SW-1:0]          id,
  output logic [31:0]            exp,
  output logic                   ins_out,
  output logic                   rem_out
);
  import stq_pkg::*;

  logic          ins_here;
  logic          valid_next;
  logic [SW-1:0] id_next;
  logic [31:0]   exp_next;

  // New entry goes ahead of any entry with an equal expiry.
  assign ins_here = !valid || (exp >= new_exp);
  assign ins_out  = ins_here;
  assign rem_out  = rem_in || (valid && (id == rem_id));

  always_comb begin
    valid_next = valid;
    id_next    = id;
    exp_next   = exp;
    if (ctrl.ins) begin
      if (ins_in) begin
        valid_next = left_valid;
        id_next    = left_id;
        exp_next   = left_exp;
      end else if (ins_here) begin
        valid_next = 1'b1;
        id_next    = new_id;
        exp_next   = new_exp;
      end
    end else if (ctrl.rem && rem_out) begin
      valid_next = right_valid;
      id_next    = right_id;
      exp_next   = right_exp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    id  <= id_next;
    exp <= exp_next;
  end

endmodule

FILE: rtl/stq_chain.sv
// Row of list cells; insert shifts right, remove shifts left.
module stq_chain #(
  parameter int NUM_TIMERS = 32,
  parameter int SW = 5
) (
  input  logic                     clk,
  input  logic                     rst,
  input  stq_pkg::stq_chain_ctrl_t ctrl,
  input  logic [SW-1:0]            new_id,
  input  logic [31:0]              new_exp,
  input  logic [SW-1:0]            rem_id,
  output logic                     head_valid,
  output logic [SW-1:0]            head_id,
  output logic [31:0]              head_exp
);
  import stq_pkg::*;

  logic          c_valid [NUM_TIMERS+1];
  logic [SW-1:0] c_id    [NUM_TIMERS+1];
  logic [31:0]   c_exp   [NUM_TIMERS+1];
  logic          c_ins   [NUM_TIMERS+1];
  logic          c_rem   [NUM_TIMERS+1];

  // Past the tail: empty entry.
  assign c_valid[NUM_TIMERS] = 1'b0;
  assign c_id[NUM_TIMERS]    = '0;
  assign c_exp[NUM_TIMERS]   = '0;
  assign c_ins[NUM_TIMERS]   = 1'b0;
  assign c_rem[NUM_TIMERS]   = 1'b0;

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    logic          l_valid;
    logic [SW-1:0] l_id;
    logic [31:0]   l_exp;
    logic          l_ins;
    logic          l_rem;
    if (i == 0) begin : g_head
      assign l_valid = 1'b0;
      assign l_id    = '0;
      assign l_exp   = '0;
      assign l_ins   = 1'b0;
      assign l_rem   = 1'b0;
    end else begin : g_body
      assign l_valid = c_valid[i-1];
      assign l_id    = c_id[i-1];
      assign l_exp   = c_exp[i-1];
      assign l_ins   = c_ins[i-1];
      assign l_rem   = c_rem[i-1];
    end
    stq_cell #(.SW(SW)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .new_id     (new_id),
      .new_exp    (new_exp),
      .rem_id     (rem_id),
      .left_valid (l_valid),
      .left_id    (l_id),
      .left_exp   (l_exp),
      .right_valid(c_valid[i+1]),
      .right_id   (c_id[i+1]),
      .right_exp  (c_exp[i+1]),
      .ins_in     (l_ins),
      .rem_in     (l_rem),
      .valid      (c_valid[i]),
      .id         (c_id[i]),
      .exp        (c_exp[i]),
      .ins_out    (c_ins[i]),
      .rem_out    (c_rem[i])
    );
  end

  assign head_valid = c_valid[0];
  assign head_id    = c_id[0];
  assign head_exp   = c_exp[0];

endmodule

FILE: rtl/sorted_timer_queue_top.sv
// Top level of the sorted one-shot timer queue.
//
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+---------------------------------------
//  s_      | in  | s_tvalid / s_tready       | s_tuser func; s_tdata slot..delay
//  m_      | out | m_tvalid / m_tready       | m_tuser kind; m_tdata; m_tlast last
//  cfg_    | in  | cfg_valid / cfg_ready     | cfg_data task_timer_slot
//
// A command passes through the execute and status states (arm adds an insert state); allocate and cancel-all walk
//   the slot table one slot per cycle.
// A tick pops expired timers from the list head, then passes through the task and finish states.
// The list is a row of cells: one insert or one remove per cycle.
// A full output register stalls the sequencer; one result is held back so
//   that the final one can carry tlast.
// Reset (rst, synchronous) empties the list, frees every slot, clears the count.
module sorted_timer_queue_top #(
  parameter int NUM_TIMERS = stq_pkg::NUM_TIMERS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // [2:0] func
  input  logic [stq_pkg::FUNC_W-1:0]  s_tuser,
  // [4:0] slot, [12:5] owner, [44:13] payload, [45] cancelable, [77:46] delay
  input  logic [stq_pkg::IN_W-1:0]    s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // [1:0] kind
  output logic [stq_pkg::KIND_W-1:0]  m_tuser,
  // [4:0] slot_out, [12:5] owner_out, [44:13] payload_out, [45] ok
  output logic [stq_pkg::OUT_W-1:0]   m_tdata,
  output logic                        m_tlast,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [stq_pkg::SLOT_W-1:0]  cfg_data
);
  import stq_pkg::*;

  localparam int SW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [SW-1:0] LAST_IDX = SW'(NUM_TIMERS - 1);

  stq_state_t state, state_next;

  // latched request
  logic [FUNC_W-1:0]  req_func;
  logic [SLOT_W-1:0]  req_slot;
  logic [OWNER_W-1:0] req_owner;
  logic [DATA_W-1:0]  req_payload;
  logic               req_canc;
  logic [DATA_W-1:0]  req_delay;

  logic [31:0]        count;
  logic [SLOT_W-1:0]  task_slot;

  // per-slot tables
  logic [1:0]         status  [NUM_TIMERS];
  logic               canc    [NUM_TIMERS];
  logic [OWNER_W-1:0] owner   [NUM_TIMERS];
  logic [DATA_W-1:0]  payload [NUM_TIMERS];

  logic [SW-1:0]        idx;
  logic [OUT_CNT_W-1:0] n_out;
  logic                 ts_flag;
  logic                 res_ok;
  logic [SLOT_W-1:0]    res_slot;

  // held-back result
  logic               pend_valid;
  logic [KIND_W-1:0]  pend_kind;
  logic [SLOT_W-1:0]  pend_slot;
  logic [OWNER_W-1:0] pend_owner;
  logic [DATA_W-1:0]  pend_payload;

  // output register
  logic [KIND_W-1:0]  out_kind;
  logic [SLOT_W-1:0]  out_slot;
  logic [OWNER_W-1:0] out_owner;
  logic [DATA_W-1:0]  out_payload;
  logic               out_ok;
  logic               out_last;

  // list
  stq_chain_ctrl_t chain_ctrl;
  logic [SW-1:0]   new_id;
  logic [31:0]     new_exp;
  logic [SW-1:0]   rem_id;
  logic            head_valid;
  logic [SW-1:0]   head_id;
  logic [31:0]     head_exp;

  logic               s_acc;
  logic               out_free;
  logic               slot_ok;
  logic [SW-1:0]      req_idx;
  logic               room;
  logic               head_expired;
  logic               head_is_task;
  logic               ca_hit;
  logic               pop;
  logic               push;
  logic               flush;
  logic               status_wr;
  logic [KIND_W-1:0]  push_kind;
  logic [SLOT_W-1:0]  push_slot;
  logic [OWNER_W-1:0] push_owner;
  logic [DATA_W-1:0]  push_payload;

  assign s_tready  = (state == S_IDLE);
  assign s_acc     = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;

  assign slot_ok = (32'(req_slot) < 32'(NUM_TIMERS));
  assign req_idx = SW'(req_slot);
  assign room    = (n_out < OUT_CNT_W'(MAX_OUT));

  assign head_expired = head_valid && (head_exp <= count) && room;
  assign head_is_task = (32'(head_id) == 32'(task_slot));
  assign ca_hit = (status[idx] != ST_FREE) && canc[idx] && (owner[idx] == req_owner);

  stq_chain #(.NUM_TIMERS(NUM_TIMERS), .SW(SW)) u_chain (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (chain_ctrl),
    .new_id    (new_id),
    .new_exp   (new_exp),
    .rem_id    (rem_id),
    .head_valid(head_valid),
    .head_id   (head_id),
    .head_exp  (head_exp)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_acc) begin
          priority if (s_tuser == FUNC_TICK)            state_next = S_POP;
          else if (s_tuser == FUNC_ALLOC)               state_next = S_ALLOC;
          else if (s_tuser == FUNC_CANCEL_ALL)          state_next = S_CANCEL_ALL;
          else                                          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (req_func == FUNC_ARM && slot_ok && status[req_idx] != ST_FREE) begin
          state_next = S_ARM_INS;
        end else begin
          state_next = S_STATUS;
        end
      end
      S_ARM_INS: state_next = S_STATUS;
      S_ALLOC: begin
        if (status[idx] == ST_FREE || idx == LAST_IDX) state_next = S_STATUS;
      end
      S_CANCEL_ALL: begin
        if (idx == LAST_IDX) state_next = S_STATUS;
      end
      S_POP: begin
        if (!head_expired) state_next = S_TS;
      end
      S_TS: begin
        if (!(ts_flag && room && !out_free)) state_next = S_FIN;
      end
      S_FIN: begin
        if (!(pend_valid && !out_free)) state_next = S_IDLE;
      end
      S_STATUS: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // per-state controls
  always_comb begin
    chain_ctrl   = '0;
    new_id       = req_idx;
    new_exp      = req_delay + count;
    rem_id       = req_idx;
    pop          = 1'b0;
    push         = 1'b0;
    flush        = 1'b0;
    status_wr    = 1'b0;
    push_kind    = KIND_DELIVER;
    push_slot    = SLOT_W'(head_id);
    push_owner   = owner[head_id];
    push_payload = payload[head_id];
    unique case (state)
      S_EXEC: begin
        chain_ctrl.rem = slot_ok && (status[req_idx] == ST_RUN) &&
                         (req_func == FUNC_ARM || req_func == FUNC_CANCEL ||
                          req_func == FUNC_FREE);
      end
      S_ARM_INS: chain_ctrl.ins = 1'b1;
      S_CANCEL_ALL: begin
        chain_ctrl.rem = ca_hit && (status[idx] == ST_RUN);
        rem_id         = idx;
      end
      S_POP: begin
        if (head_expired && out_free) begin
          chain_ctrl.rem = 1'b1;
          rem_id         = head_id;
          pop            = 1'b1;
          push           = !head_is_task;
        end
      end
      S_TS: begin
        push         = ts_flag && room && out_free;
        push_kind    = KIND_TASK;
        push_slot    = task_slot;
        push_owner   = '0;
        push_payload = '0;
      end
      S_FIN:    flush     = pend_valid && out_free;
      S_STATUS: status_wr = out_free;
      default: ;
    endcase
  end

  // control state and slot status
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      task_slot  <= '0;
      idx        <= '0;
      n_out      <= '0;
      ts_flag    <= 1'b0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        status[i] <= ST_FREE;
        canc[i]   <= 1'b0;
      end
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) task_slot <= cfg_data;

      unique case (state)
        S_IDLE: begin
          if (s_acc) begin
            idx     <= '0;
            n_out   <= '0;
            ts_flag <= 1'b0;
            if (s_tuser == FUNC_TICK) count <= count + 32'd1;
          end
        end
        S_EXEC: begin
          if (slot_ok) begin
            if (req_func == FUNC_SETUP) begin
              canc[req_idx] <= req_canc;
            end else if (req_func == FUNC_CANCEL && status[req_idx] == ST_RUN) begin
              status[req_idx] <= ST_ALLOC;
            end else if (req_func == FUNC_FREE) begin
              status[req_idx] <= ST_FREE;
            end
          end
        end
        S_ARM_INS: status[req_idx] <= ST_RUN;
        S_ALLOC: begin
          if (status[idx] == ST_FREE) begin
            status[idx] <= ST_ALLOC;
            canc[idx]   <= 1'b0;
          end
          idx <= idx + SW'(1);
        end
        S_CANCEL_ALL: begin
          if (ca_hit) status[idx] <= ST_FREE;
          idx <= idx + SW'(1);
        end
        S_POP: begin
          if (pop) begin
            status[head_id] <= ST_ALLOC;
            if (head_is_task) ts_flag <= 1'b1;
          end
        end
        default: ;
      endcase

      if (push) begin
        n_out      <= n_out + OUT_CNT_W'(1);
        pend_valid <= 1'b1;
      end
      if (flush) pend_valid <= 1'b0;
      // output register loads only when it is free
      m_tvalid <= (m_tvalid && !m_tready) || (push && pend_valid) || flush || status_wr;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_acc) begin
      req_func    <= s_tuser;
      req_slot    <= s_tdata[4:0];
      req_owner   <= s_tdata[12:5];
      req_payload <= s_tdata[44:13];
      req_canc    <= s_tdata[45];
      req_delay   <= s_tdata[77:46];
      res_ok      <= 1'b0;
      if (s_tuser == FUNC_SETUP || s_tuser == FUNC_ARM ||
          s_tuser == FUNC_CANCEL || s_tuser == FUNC_FREE) begin
        res_slot <= s_tdata[4:0];
      end else begin
        res_slot <= '0;
      end
    end

    unique case (state)
      S_EXEC: begin
        if (slot_ok) begin
          if (req_func == FUNC_SETUP) begin
            owner[req_idx]   <= req_owner;
            payload[req_idx] <= req_payload;
            res_ok           <= 1'b1;
          end else if (req_func == FUNC_ARM || req_func == FUNC_FREE) begin
            res_ok <= (status[req_idx] != ST_FREE);
          end else if (req_func == FUNC_CANCEL) begin
            res_ok <= (status[req_idx] == ST_RUN);
          end
        end
      end
      S_ALLOC: begin
        if (status[idx] == ST_FREE) begin
          res_ok   <= 1'b1;
          res_slot <= SLOT_W'(idx);
        end
      end
      S_CANCEL_ALL: begin
        if (ca_hit) res_ok <= 1'b1;
      end
      default: ;
    endcase

    if (push) begin
      pend_kind    <= push_kind;
      pend_slot    <= push_slot;
      pend_owner   <= push_owner;
      pend_payload <= push_payload;
    end
    if ((push && pend_valid) || flush) begin
      out_kind    <= pend_kind;
      out_slot    <= pend_slot;
      out_owner   <= pend_owner;
      out_payload <= pend_payload;
      out_ok      <= 1'b0;
      out_last    <= flush;
    end
    if (status_wr) begin
      out_kind    <= KIND_STATUS;
      out_slot    <= res_slot;
      out_owner   <= '0;
      out_payload <= '0;
      out_ok      <= res_ok;
      out_last    <= 1'b1;
    end
  end

  assign m_tuser = out_kind;
  assign m_tlast = out_last;
  assign m_tdata = {2'b00, out_ok, out_payload, out_owner, out_slot};

endmodule

FILE: rtl/stq_checker.sv
// Port-level checks of the timer queue, bound to the top level.
`include "sorted_timer_queue_top_macros.svh"

module stq_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic [stq_pkg::FUNC_W-1:0]  s_tuser,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [stq_pkg::KIND_W-1:0]  m_tuser,
  input logic [stq_pkg::OUT_W-1:0]   m_tdata,
  input logic                        m_tlast
);
  import stq_pkg::*;

  `STQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
  `STQ_ASSERT_NEXT(a_cmd_busy, s_tvalid && s_tready && s_tuser != FUNC_TICK, !s_tready, "command not sequenced")
  `STQ_ASSERT_NOW(a_status_last, m_tvalid && m_tuser == KIND_STATUS, m_tlast, "status not final")
  `STQ_ASSERT_NOW(a_expiry_ok, m_tvalid && m_tuser != KIND_STATUS, !m_tdata[45] && m_tuser != KIND_BAD, "bad expiry result")

endmodule

bind sorted_timer_queue_top stq_checker u_stq_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .s_tuser (s_tuser),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tuser (m_tuser),
  .m_tdata (m_tdata),
  .m_tlast (m_tlast)
);
